// ----- rtl/core/opf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opf_pkg
// Shared types and constants of the overwrite packet fifo.
// ----------------------------------------------------------------------------
package opf_pkg;

  localparam int OPF_ENTRIES      = 16;
  localparam int OPF_PACKET_BYTES = 64;

  localparam int COMMAND_W     = 2;
  localparam int BYTE_W        = 8;
  localparam int STATUS_W      = 3;
  localparam int ENTRY_COUNT_W = 5;
  localparam int PEEK_W        = 4;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 4;

  // input commands
  localparam logic [COMMAND_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [COMMAND_W-1:0] CMD_POP   = 2'd1;
  localparam logic [COMMAND_W-1:0] CMD_PEEK  = 2'd2;
  localparam logic [COMMAND_W-1:0] CMD_FLUSH = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_BYTE     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PUSHED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DISABLED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_SHUTDOWN = 3'd6;
  localparam logic [STATUS_W-1:0] ST_FLUSHED  = 3'd7;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PUSH_ENABLE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHUT_DOWN   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PEEK_LIMIT  = 2'd2;

  localparam logic [PEEK_W-1:0] PEEK_LIMIT_RESET = 4'd5;

  typedef struct packed {
    logic [COMMAND_W-1:0] command;
    logic [BYTE_W-1:0]    data_byte;
    logic                 last;
  } opf_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [BYTE_W-1:0]        data_byte_res;
    logic                     last_res;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic                     head_dropped;
  } opf_out_t;

  // controller to datapath
  typedef struct packed {
    logic                stage_wr;   // stage the incoming byte
    logic                stage_clr;  // empty the staging buffer
    logic                commit;     // advance indices for a new packet
    logic                copy_step;  // one step of staging to store copy
    logic                len_wr;     // record committed length
    logic                pop;        // pop: free head, clear peek counter
    logic                peek;       // peek: count, maybe drop head
    logic                flush;
    logic                hd_clr;
    logic                rd_first;   // read length and byte zero
    logic                rd_next;    // read following byte
    logic                out_load;
    logic [STATUS_W-1:0] out_status;
    logic                out_last;
    logic                out_byte;   // result carries a stored byte
  } opf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic peek_empty;
    logic overflow;
    logic push_enable;
    logic shut_down;
    logic dropped;
    logic copy_done;
    logic emit_last;
  } opf_stat_t;

endpackage

// ----- rtl/core/opf_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opf_datapath
// Packet store, length store, staging buffer, ring indices, configuration
// registers and the result register.
// ----------------------------------------------------------------------------
module opf_datapath #(
  parameter int ENTRIES      = opf_pkg::OPF_ENTRIES,
  parameter int PACKET_BYTES = opf_pkg::OPF_PACKET_BYTES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  opf_pkg::opf_in_t                    in_item,
  input  opf_pkg::opf_cmd_t                   cmd,
  output opf_pkg::opf_stat_t                  stat,
  input  logic                                cfg_we,
  input  logic [opf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [opf_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                out_strobe,
  output opf_pkg::opf_out_t                   out_result
);
  import opf_pkg::*;

  localparam int SW          = $clog2(ENTRIES);
  localparam int CW          = $clog2(ENTRIES + 1);
  localparam int OFFW        = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam int LENW        = $clog2(PACKET_BYTES + 1);
  localparam int STORE_DEPTH = ENTRIES * (2 ** OFFW);

  logic [BYTE_W-1:0] store_mem [STORE_DEPTH];
  logic [LENW-1:0]   len_mem   [ENTRIES];
  logic [BYTE_W-1:0] stg_mem   [PACKET_BYTES];

  logic [SW-1:0]     head_r, head_nxt, tail_r, tail_nxt, es_r, es_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [PEEK_W-1:0] pc_r, pc_nxt, limit_r;
  logic              hd_r, hd_nxt, dropped_r, dropped_nxt;
  logic              push_en_r, shut_r;
  logic [LENW-1:0]   stage_len_r, cp_r, bi_r, cp_m1, len_c;
  logic              ovf_r;
  logic [LENW-1:0]   len_q;
  logic [BYTE_W-1:0] stg_q, pkt_q;
  logic              out_valid_r;
  opf_out_t          out_r;

  logic [SW-1:0]     head_inc, tail_inc;
  logic [PEEK_W-1:0] pc_inc;
  logic              empty, pk_drop, do_drop;
  logic [OFFW-1:0]   rd_off;

  assign head_inc = (head_r == SW'(ENTRIES - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == SW'(ENTRIES - 1)) ? '0 : tail_r + 1'b1;
  assign empty    = (cnt_r == '0);
  assign pc_inc   = pc_r + 1'b1;
  assign pk_drop  = (pc_inc >= limit_r);
  assign do_drop  = cmd.pop || (cmd.peek && pk_drop);
  assign cp_m1    = cp_r - 1'b1;

  // a stored length outside the legal range is clamped
  always_comb begin
    if (len_q == '0) begin
      len_c = LENW'(1);
    end else if (len_q > LENW'(PACKET_BYTES)) begin
      len_c = LENW'(PACKET_BYTES);
    end else begin
      len_c = len_q;
    end
  end

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    cnt_nxt     = cnt_r;
    es_nxt      = es_r;
    pc_nxt      = pc_r;
    hd_nxt      = hd_r;
    dropped_nxt = dropped_r;
    if (cmd.commit) begin
      if (empty) begin
        head_nxt    = '0;
        tail_nxt    = '0;
        dropped_nxt = 1'b0;
      end else begin
        tail_nxt    = tail_inc;
        dropped_nxt = (tail_inc == head_r);
        if (tail_inc == head_r) begin
          head_nxt = head_inc;
        end
      end
      if (cnt_r != CW'(ENTRIES)) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    if (do_drop && !empty) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        head_nxt = '0;
        tail_nxt = '0;
      end else begin
        head_nxt = head_inc;
      end
    end
    if (cmd.pop) begin
      es_nxt = head_r;
      pc_nxt = '0;
    end
    if (cmd.peek) begin
      es_nxt = (pk_drop && cnt_r > CW'(1)) ? head_inc : head_r;
      pc_nxt = pk_drop ? '0 : pc_inc;
      hd_nxt = pk_drop && !empty;
    end else if (cmd.hd_clr) begin
      hd_nxt = 1'b0;
    end
    if (cmd.flush) begin
      cnt_nxt  = '0;
      head_nxt = '0;
      tail_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      pc_r        <= '0;
      hd_r        <= 1'b0;
      dropped_r   <= 1'b0;
      es_r        <= '0;
      stage_len_r <= '0;
      ovf_r       <= 1'b0;
      cp_r        <= '0;
      bi_r        <= '0;
      push_en_r   <= 1'b1;
      shut_r      <= 1'b0;
      limit_r     <= PEEK_LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      pc_r        <= pc_nxt;
      hd_r        <= hd_nxt;
      dropped_r   <= dropped_nxt;
      es_r        <= es_nxt;
      out_valid_r <= cmd.out_load;
      if (cmd.stage_clr) begin
        stage_len_r <= '0;
        ovf_r       <= 1'b0;
      end else if (cmd.stage_wr) begin
        if (stage_len_r < LENW'(PACKET_BYTES)) begin
          stage_len_r <= stage_len_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        cp_r <= '0;
      end else if (cmd.copy_step) begin
        cp_r <= cp_r + 1'b1;
      end
      if (cmd.rd_first) begin
        bi_r <= LENW'(1);
      end else if (cmd.rd_next) begin
        bi_r <= bi_r + 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PUSH_ENABLE: push_en_r <= cfg_data[0];
          REG_SHUT_DOWN:   shut_r    <= cfg_data[0];
          REG_PEEK_LIMIT:  limit_r   <= cfg_data[PEEK_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // staging buffer
  always_ff @(posedge clk) begin
    if (cmd.stage_wr && stage_len_r < LENW'(PACKET_BYTES)) begin
      stg_mem[stage_len_r[OFFW-1:0]] <= in_item.data_byte;
    end
    if (cmd.copy_step && cp_r < stage_len_r) begin
      stg_q <= stg_mem[cp_r[OFFW-1:0]];
    end
  end

  // packet store: each copy write lands in the cycle after its staging read
  assign rd_off = cmd.rd_first ? '0 : bi_r[OFFW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.copy_step && cp_r != '0) begin
      store_mem[{tail_r, cp_m1[OFFW-1:0]}] <= stg_q;
    end
    if (cmd.rd_first || cmd.rd_next) begin
      pkt_q <= store_mem[{es_r, rd_off}];
    end
  end

  // length store
  always_ff @(posedge clk) begin
    if (cmd.len_wr) begin
      len_mem[tail_r] <= stage_len_r;
    end
    if (cmd.rd_first) begin
      len_q <= len_mem[es_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.status        <= cmd.out_status;
      out_r.data_byte_res <= cmd.out_byte ? pkt_q : '0;
      out_r.last_res      <= cmd.out_last;
      out_r.entry_count   <= ENTRY_COUNT_W'(cnt_nxt);
      out_r.head_dropped  <= hd_nxt;
    end
  end

  assign out_strobe = out_valid_r;
  assign out_result = out_r;

  assign stat.empty       = empty;
  assign stat.peek_empty  = empty || (pk_drop && cnt_r == CW'(1));
  assign stat.overflow    = ovf_r || (stage_len_r == LENW'(PACKET_BYTES));
  assign stat.push_enable = push_en_r;
  assign stat.shut_down   = shut_r;
  assign stat.dropped     = dropped_r;
  assign stat.copy_done   = (cp_r == stage_len_r);
  assign stat.emit_last   = (bi_r == len_c);

endmodule

// ----- rtl/core/opf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opf_ctrl
// Command sequencer: decodes accepted words, runs the commit copy and the
// byte streaming of pop and peek.
// ----------------------------------------------------------------------------
module opf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  opf_pkg::opf_in_t    in_item,
  input  opf_pkg::opf_stat_t  stat,
  output opf_pkg::opf_cmd_t   cmd
);
  import opf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_COPY = 2'd1;
  localparam logic [1:0] S_LEN  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_item.command)
            CMD_PUSH: begin
              cmd.stage_wr = 1'b1;
              cmd.hd_clr   = 1'b1;
              if (in_item.last) begin
                if (!stat.push_enable) begin
                  cmd.stage_clr  = 1'b1;
                  cmd.out_load   = 1'b1;
                  cmd.out_status = ST_DISABLED;
                  cmd.out_last   = 1'b1;
                end else if (stat.overflow) begin
                  cmd.stage_clr  = 1'b1;
                  cmd.out_load   = 1'b1;
                  cmd.out_status = ST_TOO_LONG;
                  cmd.out_last   = 1'b1;
                end else begin
                  cmd.commit = 1'b1;
                  state_nxt  = S_COPY;
                end
              end
            end
            CMD_POP: begin
              cmd.pop    = 1'b1;
              cmd.hd_clr = 1'b1;
              if (stat.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_EMPTY;
                cmd.out_last   = 1'b1;
              end else begin
                state_nxt = S_LEN;
              end
            end
            CMD_PEEK: begin
              if (stat.shut_down) begin
                cmd.hd_clr     = 1'b1;
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_SHUTDOWN;
                cmd.out_last   = 1'b1;
              end else begin
                cmd.peek = 1'b1;
                if (stat.peek_empty) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_status = ST_EMPTY;
                  cmd.out_last   = 1'b1;
                end else begin
                  state_nxt = S_LEN;
                end
              end
            end
            CMD_FLUSH: begin
              cmd.flush      = 1'b1;
              cmd.hd_clr     = 1'b1;
              cmd.out_load   = 1'b1;
              cmd.out_status = ST_FLUSHED;
              cmd.out_last   = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (stat.copy_done) begin
          cmd.len_wr     = 1'b1;
          cmd.stage_clr  = 1'b1;
          cmd.out_load   = 1'b1;
          cmd.out_status = stat.dropped ? ST_DROPPED : ST_PUSHED;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_LEN: begin
        cmd.rd_first = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        cmd.out_load   = 1'b1;
        cmd.out_status = ST_BYTE;
        cmd.out_byte   = 1'b1;
        cmd.out_last   = stat.emit_last;
        if (stat.emit_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- rtl/core/overwrite_packet_fifo_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwrite_packet_fifo_unit
// Ring queue of variable-length packets that overwrites the oldest when full.
// ----------------------------------------------------------------------------
// A word is taken on a rising edge with start high and busy low; each result
// appears on out_result for exactly one cycle with out_strobe high, and the
// receiver cannot stall, so it must take every strobed word. A pushed byte
// that is not last gives no result and leaves the block free. A rejected
// last byte, a flush, a shutdown peek or a pop or peek of an empty queue
// gives its one result in the next cycle and the block is free again at
// once. A committed packet of n bytes is copied from the staging buffer into
// the packet store one byte a cycle with busy high, and the status word
// follows the copy. A pop or peek of a packet of n bytes first does the
// registered length read, then streams one byte per cycle with busy high,
// the last byte strobed in the same cycle that busy falls.
// ----------------------------------------------------------------------------
module overwrite_packet_fifo_unit #(
  parameter int ENTRIES      = opf_pkg::OPF_ENTRIES,
  parameter int PACKET_BYTES = opf_pkg::OPF_PACKET_BYTES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  opf_pkg::opf_in_t                in_item,
  output logic                            out_strobe,
  output opf_pkg::opf_out_t               out_result,
  input  logic                            cfg_we,
  input  logic [opf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [opf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import opf_pkg::*;

  opf_cmd_t  cmd;
  opf_stat_t stat;

  opf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .stat    (stat),
    .cmd     (cmd)
  );

  opf_datapath #(
    .ENTRIES      (ENTRIES),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

endmodule

// ----- sim/overwrite_packet_fifo_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwrite_packet_fifo_unit_tb
// Self-checking bench for the overwrite packet fifo. A queue of command words
// feeds a falling-edge driver and a rising-edge monitor keeps its own copy of
// the ring queue and its registers. The monitor works out the result words of
// every accepted command and checks each strobed result, field by field,
// against the oldest one due. The run steps through several register settings
// and sender idle rates: directed words first, then mostly well-formed random
// packets with pops, peeks, flushes and stray bytes mixed in.
// ----------------------------------------------------------------------------
module overwrite_packet_fifo_unit_tb;
  import opf_pkg::*;

  localparam int DEPTH    = OPF_ENTRIES;
  localparam int MAXLEN   = OPF_PACKET_BYTES;
  localparam int WATCHDOG = 3000;
  localparam int SETTLE   = 4;
  localparam int TAIL     = 80;

  typedef struct {
    opf_in_t word;
    bit      drain;  // hold this word until every due result has come
  } send_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  opf_in_t                in_item = '0;
  logic                   out_strobe;
  opf_out_t               out_result;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  send_t    words_to_send[$];
  opf_out_t due_results[$];
  int       send_idle_pct = 0;
  bit       word_taken = 1'b0;
  bit       go;
  send_t    nxt;
  int       errors = 0;
  int       quiet_cycles = 0;
  opf_out_t want;

  // mirror of the queue state and registers
  logic [7:0]        pkt_mem [DEPTH][MAXLEN];
  int                pkt_len [DEPTH];
  logic [7:0]        stage_mem [MAXLEN];
  int                stage_len = 0;
  bit                stage_ovf = 1'b0;
  int                head_slot = 0;
  int                tail_slot = 0;
  int                held = 0;
  logic [PEEK_W-1:0] peek_cnt = '0;
  bit                push_en = 1'b1;
  bit                shut = 1'b0;
  logic [PEEK_W-1:0] peek_lim = PEEK_LIMIT_RESET;

  overwrite_packet_fifo_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_result (out_result),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic add_due(input logic [STATUS_W-1:0] st, input logic [BYTE_W-1:0] d,
                         input logic lst, input logic hd);
    opf_out_t r;
    r.status        = st;
    r.data_byte_res = d;
    r.last_res      = lst;
    r.entry_count   = held[ENTRY_COUNT_W-1:0];
    r.head_dropped  = hd;
    due_results.push_back(r);
  endtask

  task automatic drop_oldest();
    if (held != 0) begin
      held--;
      if (held == 0) begin
        head_slot = 0;
        tail_slot = 0;
      end else begin
        head_slot = (head_slot + 1) % DEPTH;
      end
    end
  endtask

  function automatic logic [STATUS_W-1:0] commit_staged();
    bit lost;
    lost = 1'b0;
    if (held == 0) begin
      head_slot = 0;
      tail_slot = 0;
    end else begin
      tail_slot = (tail_slot + 1) % DEPTH;
      if (tail_slot == head_slot) begin
        head_slot = (head_slot + 1) % DEPTH;
        lost = 1'b1;
      end
    end
    for (int i = 0; i < MAXLEN; i++)
      pkt_mem[tail_slot][i] = (i < stage_len) ? stage_mem[i] : 8'h00;
    pkt_len[tail_slot] = stage_len;
    if (held < DEPTH) held++;
    return lost ? ST_DROPPED : ST_PUSHED;
  endfunction

  // entry count is already final when the bytes stream out
  task automatic stream_slot(input int slot, input logic hd);
    int n;
    n = pkt_len[slot];
    if (n < 1) n = 1;
    if (n > MAXLEN) n = MAXLEN;
    for (int i = 0; i < n; i++)
      add_due(ST_BYTE, pkt_mem[slot][i], i == n - 1, hd);
  endtask

  task automatic fifo_apply_word(input opf_in_t w);
    logic [STATUS_W-1:0] st;
    logic                hd;
    int                  slot;
    case (w.command)
      CMD_PUSH: begin
        if (stage_len < MAXLEN) begin
          stage_mem[stage_len] = w.data_byte;
          stage_len++;
        end else begin
          stage_ovf = 1'b1;
        end
        if (w.last) begin
          if (!push_en) st = ST_DISABLED;
          else if (stage_ovf) st = ST_TOO_LONG;
          else st = commit_staged();
          stage_len = 0;
          stage_ovf = 1'b0;
          add_due(st, 8'h00, 1'b1, 1'b0);
        end
      end
      CMD_POP: begin
        peek_cnt = '0;
        if (held == 0) begin
          add_due(ST_EMPTY, 8'h00, 1'b1, 1'b0);
        end else begin
          slot = head_slot;
          drop_oldest();
          stream_slot(slot, 1'b0);
        end
      end
      CMD_PEEK: begin
        if (shut) begin
          add_due(ST_SHUTDOWN, 8'h00, 1'b1, 1'b0);
        end else begin
          hd = 1'b0;
          peek_cnt = peek_cnt + 1'b1;
          if (peek_cnt >= peek_lim) begin
            if (held != 0) hd = 1'b1;
            drop_oldest();
            peek_cnt = '0;
          end
          if (held == 0) add_due(ST_EMPTY, 8'h00, 1'b1, hd);
          else stream_slot(head_slot, hd);
        end
      end
      CMD_FLUSH: begin
        held = 0;
        head_slot = 0;
        tail_slot = 0;
        add_due(ST_FLUSHED, 8'h00, 1'b1, 1'b0);
      end
    endcase
  endtask

  task automatic flag_error(input string what, input opf_out_t e, input opf_out_t a);
    errors++;
    if (errors <= 10)
      $display("%0t %s: exp st=%0d d=%02h l=%0b n=%0d hd=%0b got st=%0d d=%02h l=%0b n=%0d hd=%0b",
               $time, what, e.status, e.data_byte_res, e.last_res, e.entry_count,
               e.head_dropped, a.status, a.data_byte_res, a.last_res, a.entry_count,
               a.head_dropped);
  endtask

  // monitor: results first, then the word taken at this edge
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG) begin
      $display("overwrite_packet_fifo_unit_tb: done, errors");
      $finish;
    end
    if (rst_n) begin
      if (out_strobe) begin
        if (due_results.size() == 0) begin
          flag_error("unexpected word", '0, out_result);
        end else begin
          want = due_results.pop_front();
          if (out_result.status !== want.status ||
              out_result.data_byte_res !== want.data_byte_res ||
              out_result.last_res !== want.last_res ||
              out_result.entry_count !== want.entry_count ||
              out_result.head_dropped !== want.head_dropped)
            flag_error("mismatch", want, out_result);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PUSH_ENABLE: push_en = cfg_data[0];
          REG_SHUT_DOWN:   shut = cfg_data[0];
          REG_PEEK_LIMIT:  peek_lim = cfg_data[PEEK_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) fifo_apply_word(in_item);
    end
    word_taken <= start && !busy;
  end

  // driver: holds a word until taken, then picks the next or idles
  always @(negedge clk) begin
    if (rst_n && (!start || word_taken)) begin
      go = words_to_send.size() != 0;
      if (go && words_to_send[0].drain && (due_results.size() != 0 || busy)) go = 1'b0;
      if (go && $urandom_range(99) < send_idle_pct) go = 1'b0;
      if (go) begin
        nxt = words_to_send.pop_front();
        in_item <= nxt.word;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic add_word(input logic [COMMAND_W-1:0] cmd, input logic [BYTE_W-1:0] b,
                          input logic lst, input bit drain);
    send_t s;
    s.word.command   = cmd;
    s.word.data_byte = b;
    s.word.last      = lst;
    s.drain          = drain;
    words_to_send.push_back(s);
  endtask

  task automatic add_packet(input int len);
    for (int i = 0; i < len; i++)
      add_word(CMD_PUSH, BYTE_W'($urandom_range(255)), i == len - 1,
               $urandom_range(99) < 2);
  endtask

  task automatic add_random(input int n_words, input int pkt_pct);
    int made;
    int r;
    int len;
    logic [COMMAND_W-1:0] cmd;
    made = 0;
    while (made < n_words) begin
      r = $urandom_range(99);
      if (r < pkt_pct) begin
        len = ($urandom_range(99) < 85) ? $urandom_range(1, 4) : $urandom_range(5, 12);
        add_packet(len);
        made += len;
      end else if (r < 93) begin
        r = $urandom_range(99);
        cmd = (r < 45) ? CMD_POP : (r < 90) ? CMD_PEEK : CMD_FLUSH;
        add_word(cmd, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                 $urandom_range(99) < 2);
        made++;
      end else begin
        // stray byte: joins the next packet or ends a lone one
        add_word(CMD_PUSH, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
        made++;
      end
    end
  endtask

  task automatic wait_idle();
    int calm;
    calm = 0;
    while (calm < SETTLE) begin
      @(negedge clk);
      if (words_to_send.size() == 0 && !start && due_results.size() == 0 && !busy)
        calm++;
      else
        calm = 0;
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words at reset settings
    send_idle_pct = 0;
    add_word(CMD_POP, 8'hFF, 1'b1, 1'b1);
    add_word(CMD_PEEK, 8'h00, 1'b0, 1'b0);
    add_word(CMD_PUSH, 8'h00, 1'b1, 1'b0);
    add_word(CMD_PUSH, 8'hFF, 1'b0, 1'b0);
    add_word(CMD_PUSH, 8'hAA, 1'b1, 1'b0);
    add_word(CMD_PEEK, 8'h12, 1'b1, 1'b0);
    add_word(CMD_PEEK, 8'h34, 1'b0, 1'b0);
    add_word(CMD_POP, 8'h00, 1'b0, 1'b0);
    // flush keeps the partly staged packet
    add_word(CMD_PUSH, 8'h55, 1'b0, 1'b0);
    add_word(CMD_FLUSH, 8'hFF, 1'b1, 1'b0);
    add_word(CMD_PUSH, 8'h0F, 1'b1, 1'b0);
    // fifth peek in a row drops the head first
    repeat (5) add_word(CMD_PEEK, 8'h00, 1'b0, 1'b0);
    add_word(CMD_FLUSH, 8'h00, 1'b0, 1'b1);
    add_word(CMD_POP, 8'h80, 1'b1, 1'b1);
    wait_idle();

    // highest peek limit, queue driven past full
    write_reg(REG_PEEK_LIMIT, 4'd15);
    send_idle_pct = 62;
    for (int i = 0; i < DEPTH + 2; i++) add_packet(1);
    add_random(50, 80);
    wait_idle();

    // zero peek limit: every peek drops first
    write_reg(REG_PEEK_LIMIT, 4'd0);
    send_idle_pct = 15;
    add_random(40, 50);
    repeat (3) add_word(CMD_PEEK, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
    wait_idle();

    // pushes disabled and peeks shut down
    write_reg(REG_PUSH_ENABLE, 4'd0);
    write_reg(REG_SHUT_DOWN, 4'd1);
    send_idle_pct = 62;
    add_random(30, 55);
    wait_idle();

    // back on, limit one, longest and overlong packets
    write_reg(REG_PUSH_ENABLE, 4'd1);
    write_reg(REG_SHUT_DOWN, 4'd0);
    write_reg(REG_PEEK_LIMIT, 4'd1);
    send_idle_pct = 0;
    add_packet(MAXLEN);
    add_word(CMD_PEEK, 8'h00, 1'b0, 1'b0);
    add_packet(MAXLEN);
    add_word(CMD_POP, 8'h00, 1'b0, 1'b0);
    add_packet(MAXLEN + 1);
    add_random(30, 60);
    wait_idle();

    write_reg(REG_PEEK_LIMIT, 4'd3);
    send_idle_pct = 15;
    add_random(35, 60);
    wait_idle();

    repeat (TAIL) @(negedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("overwrite_packet_fifo_unit_tb: done, clean");
    end else begin
      $display("overwrite_packet_fifo_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
